>>> rtl/r4m_pkg.sv
// r4m_pkg: field widths, operation/action/error codes, register indexes and
// the status struct shared by the RAID 4 request mapper and its checker.
// No dependencies.
package r4m_pkg;

  localparam int ADDR_W   = 48;
  localparam int COUNT_W  = 16;
  localparam int EC_W     = 5;
  localparam int STRIP_W  = 17;
  localparam int OFFSET_W = 20;
  localparam int MASK_W   = 16;
  localparam int OP_W     = 2;
  localparam int ACT_W    = 3;
  localparam int ERR_W    = 2;
  localparam int XIDX_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // operations
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_SYNC  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // segment actions
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RECON     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WR_FULL   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WR_NOPAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PAR_ONLY  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RMW       = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SKIP      = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SYNC_ALL  = 3'd7;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNUSABLE  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_BLOCKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BLOCKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_MASK  = 3'd4;

  // volume health as seen by the sequencer
  typedef struct packed {
    logic             multi_offline;
    logic [ACT_W-1:0] seg_action;
  } r4m_status_t;

endpackage

>>> rtl/r4m_req_if.sv
// r4m_req_if: request channel (valid/ready plus request fields).
// Depends on r4m_pkg for field widths.
interface r4m_req_if import r4m_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ADDR_W-1:0]   block_address;
  logic [COUNT_W-1:0]  block_count;

  modport source (output valid, output operation, output block_address,
                  output block_count, input ready);
  modport sink   (input valid, input operation, input block_address,
                  input block_count, output ready);
endinterface

>>> rtl/r4m_res_if.sv
// r4m_res_if: result channel (valid/ready plus segment fields).
// Depends on r4m_pkg for field widths.
interface r4m_res_if import r4m_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [XIDX_W-1:0]   extent_index;
  logic [ADDR_W-1:0]   physical_block;
  logic [COUNT_W-1:0]  segment_blocks;
  logic [ACT_W-1:0]    action;
  logic [ERR_W-1:0]    error_code;
  logic                last;

  modport source (output valid, output extent_index, output physical_block,
                  output segment_blocks, output action, output error_code,
                  output last, input ready);
  modport sink   (input valid, input extent_index, input physical_block,
                  input segment_blocks, input action, input error_code,
                  input last, output ready);
endinterface

>>> rtl/r4m_cfg_if.sv
// r4m_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on r4m_pkg for widths.
interface r4m_cfg_if import r4m_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/r4m_addsub.sv
// r4m_addsub: the shared adder/subtractor used for division steps,
// multiply steps and address updates. No dependencies.
module r4m_addsub #(
  parameter int W = 48
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] full;

  // subtract as a + ~b + 1; carry set means no borrow
  assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign sum   = full[W-1:0];
  assign carry = full[W];

endmodule

>>> rtl/r4m_status.sv
// r4m_status: clamps the extent count, decodes offline extents and picks
// the action for the current segment. Depends on r4m_pkg.
module r4m_status import r4m_pkg::*; #(
  parameter int MAX_EXTENTS = 16,
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1),
  localparam int IDX_W = $clog2(MAX_EXTENTS)
) (
  input  logic [EC_W-1:0]   extent_count,
  input  logic [MASK_W-1:0] online_mask,
  input  logic [OP_W-1:0]   op,
  input  logic [IDX_W-1:0]  seg_extent,
  output logic [CNT_W-1:0]  n_ext,
  output r4m_status_t       status
);

  localparam int MASKX = (MAX_EXTENTS > MASK_W) ? MAX_EXTENTS : MASK_W;

  logic [MASKX-1:0]       mask_ext;
  logic [MAX_EXTENTS-1:0] online_vec;
  logic [MAX_EXTENTS-1:0] offline_vec;
  logic [CNT_W-1:0]       first_bad;
  logic                   any_bad;
  logic                   seg_online;
  logic                   seg_is_first;
  logic                   multi_off;
  logic [ACT_W-1:0]       seg_act;

  always_comb begin
    if (extent_count < EC_W'(3)) begin
      n_ext = CNT_W'(3);
    end else if ({1'b0, extent_count} > 6'(MAX_EXTENTS)) begin
      n_ext = CNT_W'(MAX_EXTENTS);
    end else begin
      n_ext = CNT_W'(extent_count);
    end
  end

  // extents beyond the mask are never online
  assign mask_ext   = MASKX'(online_mask);
  assign online_vec = mask_ext[MAX_EXTENTS-1:0];

  always_comb begin
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      offline_vec[i] = !online_vec[i] && (CNT_W'(i) < n_ext);
    end
  end

  always_comb begin
    first_bad = n_ext;
    for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
      if (offline_vec[i]) begin
        first_bad = CNT_W'(i);
      end
    end
  end

  assign any_bad      = |offline_vec;
  assign multi_off    = |(offline_vec & (offline_vec - MAX_EXTENTS'(1)));
  assign seg_online   = online_vec[seg_extent];
  assign seg_is_first = (CNT_W'(seg_extent) == first_bad);
  assign status       = '{multi_offline: multi_off, seg_action: seg_act};

  always_comb begin
    unique case (op)
      OP_SYNC: begin
        seg_act = seg_online ? ACT_READ : ACT_SKIP;
      end
      OP_READ: begin
        seg_act = (any_bad && (first_bad != '0) && seg_is_first)
                  ? ACT_RECON : ACT_READ;
      end
      OP_WRITE: begin
        if (!any_bad) begin
          seg_act = ACT_WR_FULL;
        end else if (first_bad == '0) begin
          seg_act = ACT_WR_NOPAR;
        end else if (seg_is_first) begin
          seg_act = ACT_PAR_ONLY;
        end else begin
          seg_act = ACT_RMW;
        end
      end
      default: begin
        seg_act = ACT_READ;
      end
    endcase
  end

endmodule

>>> rtl/raid4_request_mapper.sv
// RAID 4 request mapper. One request is taken at a time; in_ready is high
// only while the sequencer is idle. A no-operation, an empty request or a
// request rejected for range or for an unusable volume finishes in the check
// state (error or sync-all result as soon as the output register is free);
// a request that spans too many strips is rejected at the span check. A
// request that is mapped takes the check, the block / strip division, the
// span check, the strip / data extents division, the multiply and the base
// step, all on one shared 48-bit adder, then one result per segment while
// the output is taken. The last result may still wait in the output
// register while the next request is accepted.
// Depends on r4m_pkg, the channel interfaces, r4m_addsub and r4m_status.
module raid4_request_mapper import r4m_pkg::*; #(
  parameter int MAX_EXTENTS  = 16,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  r4m_req_if.sink   in_chan,
  r4m_res_if.source out_chan,
  r4m_cfg_if.sink   cfg_chan
);

  localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
  localparam int IDX_W  = $clog2(MAX_EXTENTS);
  localparam int STEP_W = $clog2(ADDR_W);
  localparam int LIM_W  = STRIP_W + $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_DIV_STRIP, ST_SPAN, ST_DIV_ROW, ST_MUL, ST_BASE, ST_SEG
  } state_t;

  // configuration
  logic [EC_W-1:0]     extent_count_r;
  logic [STRIP_W-1:0]  strip_blocks_r;
  logic [OFFSET_W-1:0] data_offset_r;
  logic [ADDR_W-1:0]   data_blocks_r;
  logic [MASK_W-1:0]   online_mask_r;

  // sequencer and datapath
  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [ADDR_W-1:0]   dq_r, dq_nxt;
  logic [STRIP_W-1:0]  rem_r, rem_nxt;
  logic [STRIP_W-1:0]  soff_r, soff_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [ADDR_W-1:0]   acc_r, acc_nxt;
  logic [ADDR_W-1:0]   mcand_r, mcand_nxt;
  logic [STRIP_W-1:0]  mplier_r, mplier_nxt;
  logic [ADDR_W-1:0]   pb_r, pb_nxt;
  logic [IDX_W-1:0]    extent_r, extent_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [XIDX_W-1:0]   out_ext_r, out_ext_nxt;
  logic [ADDR_W-1:0]   out_pb_r, out_pb_nxt;
  logic [COUNT_W-1:0]  out_seg_r, out_seg_nxt;
  logic [ACT_W-1:0]    out_act_r, out_act_nxt;
  logic [ERR_W-1:0]    out_err_r, out_err_nxt;
  logic                out_last_r, out_last_nxt;

  // shared unit
  logic [ADDR_W-1:0]   alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_carry;

  logic [CNT_W-1:0]    n_ext;
  logic [CNT_W-1:0]    n_m1;
  r4m_status_t         status;
  logic [STRIP_W-1:0]  strip_eff;
  logic [STRIP_W:0]    rem_sh;
  logic                out_free;
  logic [ADDR_W:0]     range_end;
  logic                sync_all;
  logic [LIM_W-1:0]    span_lim;
  logic [LIM_W-1:0]    span;
  logic [STRIP_W-1:0]  room;
  logic [COUNT_W-1:0]  seg_cnt;
  logic [COUNT_W-1:0]  seg_left;
  logic                seg_wrap;
  logic [IDX_W+XIDX_W-1:0] ext_pad;

  r4m_addsub #(.W(ADDR_W)) u_addsub (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  r4m_status #(.MAX_EXTENTS(MAX_EXTENTS)) u_status (
    .extent_count (extent_count_r),
    .online_mask  (online_mask_r),
    .op           (op_r),
    .seg_extent   (extent_r),
    .n_ext        (n_ext),
    .status       (status)
  );

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == ST_IDLE);

  assign out_chan.valid          = out_valid_r;
  assign out_chan.extent_index   = out_ext_r;
  assign out_chan.physical_block = out_pb_r;
  assign out_chan.segment_blocks = out_seg_r;
  assign out_chan.action         = out_act_r;
  assign out_chan.error_code     = out_err_r;
  assign out_chan.last           = out_last_r;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign strip_eff = (strip_blocks_r == '0) ? STRIP_W'(1) : strip_blocks_r;
  assign n_m1      = n_ext - CNT_W'(1);
  assign rem_sh    = {rem_r, dq_r[ADDR_W-1]};
  assign range_end = {1'b0, dq_r} + (ADDR_W + 1)'(left_r);
  assign sync_all  = (op_r == OP_SYNC) && (dq_r == '0) && (left_r == '0);
  assign span_lim  = LIM_W'(strip_eff) * LIM_W'(MAX_SEGMENTS);
  assign span      = LIM_W'(soff_r) + LIM_W'(left_r);
  assign room      = strip_eff - soff_r;
  assign seg_cnt   = (STRIP_W'(left_r) < room) ? left_r : room[COUNT_W-1:0];
  assign seg_left  = left_r - seg_cnt;
  assign seg_wrap  = ((CNT_W + 1)'(extent_r) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(n_ext);
  assign ext_pad   = {{XIDX_W{1'b0}}, extent_r};

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_DIV_STRIP: begin
        alu_a   = ADDR_W'(rem_sh);
        alu_b   = ADDR_W'(strip_eff);
        alu_sub = 1'b1;
      end
      ST_DIV_ROW: begin
        alu_a   = ADDR_W'(rem_sh);
        alu_b   = ADDR_W'(n_m1);
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_a = acc_r;
        alu_b = mplier_r[0] ? mcand_r : '0;
      end
      ST_BASE: begin
        alu_a = acc_r;
        alu_b = ADDR_W'(soff_r);
      end
      ST_SEG: begin
        alu_a = acc_r;
        alu_b = ADDR_W'(strip_eff);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    soff_nxt      = soff_r;
    left_nxt      = left_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    pb_nxt        = pb_r;
    extent_nxt    = extent_r;
    out_valid_nxt = out_valid_r;
    out_ext_nxt   = out_ext_r;
    out_pb_nxt    = out_pb_r;
    out_seg_nxt   = out_seg_r;
    out_act_nxt   = out_act_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;

    // drop the result once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          op_nxt    = in_chan.operation;
          dq_nxt    = in_chan.block_address;
          left_nxt  = in_chan.block_count;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (op_r == OP_NOP) begin
          state_nxt = ST_IDLE;
        end else if (sync_all || (range_end > {1'b0, data_blocks_r}) ||
                     status.multi_offline) begin
          // single result transaction
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_ext_nxt   = '0;
            out_pb_nxt    = '0;
            out_seg_nxt   = '0;
            out_last_nxt  = 1'b1;
            if (sync_all) begin
              out_act_nxt = ACT_SYNC_ALL;
              out_err_nxt = status.multi_offline ? ERR_UNUSABLE : ERR_OK;
            end else if (range_end > {1'b0, data_blocks_r}) begin
              out_act_nxt = ACT_READ;
              out_err_nxt = ERR_RANGE;
            end else begin
              out_act_nxt = ACT_READ;
              out_err_nxt = ERR_UNUSABLE;
            end
            state_nxt = ST_IDLE;
          end
        end else if (left_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV_STRIP;
        end
      end
      ST_DIV_STRIP, ST_DIV_ROW: begin
        // one restoring division step per cycle
        rem_nxt  = alu_carry ? alu_sum[STRIP_W-1:0] : rem_sh[STRIP_W-1:0];
        dq_nxt   = {dq_r[ADDR_W-2:0], alu_carry};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ADDR_W - 1)) begin
          state_nxt = (state_r == ST_DIV_STRIP) ? ST_SPAN : ST_MUL;
          if (state_r == ST_DIV_STRIP) begin
            soff_nxt = rem_nxt;
          end else begin
            extent_nxt = rem_nxt[IDX_W-1:0] + IDX_W'(1);
            acc_nxt    = ADDR_W'(data_offset_r);
            mcand_nxt  = dq_nxt;
            mplier_nxt = strip_eff;
            step_nxt   = '0;
          end
        end
      end
      ST_SPAN: begin
        if (span > span_lim) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_ext_nxt   = '0;
            out_pb_nxt    = '0;
            out_seg_nxt   = '0;
            out_act_nxt   = ACT_READ;
            out_err_nxt   = ERR_TOO_LONG;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV_ROW;
        end
      end
      ST_MUL: begin
        // shift-add: row times strip, started from the data offset
        acc_nxt    = alu_sum;
        mcand_nxt  = {mcand_r[ADDR_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[STRIP_W-1:1]};
        step_nxt   = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STRIP_W - 1)) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        pb_nxt    = alu_sum;
        state_nxt = ST_SEG;
      end
      ST_SEG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ext_nxt   = ext_pad[XIDX_W-1:0];
          out_pb_nxt    = pb_r;
          out_seg_nxt   = seg_cnt;
          out_act_nxt   = status.seg_action;
          out_err_nxt   = ERR_OK;
          out_last_nxt  = (seg_left == '0);
          left_nxt      = seg_left;
          soff_nxt      = '0;
          // advance to the next data extent, next row after the last one
          if (seg_wrap) begin
            extent_nxt = IDX_W'(1);
            acc_nxt    = alu_sum;
            pb_nxt     = alu_sum;
          end else begin
            extent_nxt = extent_r + IDX_W'(1);
            pb_nxt     = acc_r;
          end
          if (seg_left == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    soff_r     <= soff_nxt;
    left_r     <= left_nxt;
    step_r     <= step_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    pb_r       <= pb_nxt;
    extent_r   <= extent_nxt;
    out_ext_r  <= out_ext_nxt;
    out_pb_r   <= out_pb_nxt;
    out_seg_r  <= out_seg_nxt;
    out_act_r  <= out_act_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extent_count_r <= EC_W'(3);
      strip_blocks_r <= STRIP_W'(128);
      data_offset_r  <= '0;
      data_blocks_r  <= '0;
      online_mask_r  <= '1;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_EXTENT_COUNT: extent_count_r <= cfg_chan.data[EC_W-1:0];
        CFG_STRIP_BLOCKS: strip_blocks_r <= cfg_chan.data[STRIP_W-1:0];
        CFG_DATA_OFFSET:  data_offset_r  <= cfg_chan.data[OFFSET_W-1:0];
        CFG_DATA_BLOCKS:  data_blocks_r  <= cfg_chan.data[ADDR_W-1:0];
        CFG_ONLINE_MASK:  online_mask_r  <= cfg_chan.data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/r4m_checker.sv
// r4m_assertions: port-level assertions for raid4_request_mapper, bound to
// the top level below. Depends on r4m_pkg for codes and widths.
module r4m_assertions import r4m_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic [XIDX_W-1:0]  out_extent_index,
  input logic [ADDR_W-1:0]  out_physical_block,
  input logic [COUNT_W-1:0] out_segment_blocks,
  input logic [ACT_W-1:0]   out_action,
  input logic [ERR_W-1:0]   out_error_code,
  input logic               out_last
);

  // a request keeps the block busy for at least the check cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // no new request until the final segment has been produced
  a_busy_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready before the final segment");

  // a sync-all transaction carries its own action even when unusable
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_OK) && (out_action != ACT_SYNC_ALL) |->
      out_last && (out_action == ACT_READ) && (out_extent_index == '0) &&
      (out_physical_block == '0) && (out_segment_blocks == '0))
    else $error("malformed error transaction");

  a_sync_all_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_SYNC_ALL) |->
      out_last && (out_segment_blocks == '0) && (out_physical_block == '0))
    else $error("malformed sync-all transaction");

  a_segment_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_OK) && (out_action != ACT_SYNC_ALL) |->
      (out_segment_blocks != '0))
    else $error("empty segment transaction");

endmodule

bind raid4_request_mapper r4m_assertions u_r4m_assertions (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_extent_index   (out_chan.extent_index),
  .out_physical_block (out_chan.physical_block),
  .out_segment_blocks (out_chan.segment_blocks),
  .out_action         (out_chan.action),
  .out_error_code     (out_chan.error_code),
  .out_last           (out_chan.last)
);
